// ===== rtl/dbcrsc_pkg.sv =====
// Shared types, codes, trellis functions and circulation tables for the duo-binary RSC encoder.
package dbcrsc_pkg;

    // Operation carried by an input transfer.
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    // Status returned with every read result.
    typedef enum logic [1:0]
    {
        STAT_OK        = 2'd0,
        STAT_NO_FRAME  = 2'd1,
        STAT_BAD_LEN   = 2'd2,
        STAT_MISMATCH  = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } fsm_t;

    // Input item.
    typedef struct packed
    {
        op_t  op;
        logic in_bit_a;
        logic in_bit_b;
        logic in_last;
    } in_item_t;

    // Result item.
    typedef struct packed
    {
        logic    out_bit_a;
        logic    out_bit_b;
        logic    parity_y;
        logic    parity_w;
        logic    out_last;
        status_t status;
    } out_item_t;

    localparam int CIRC8_ROWS  = 6;
    localparam int CIRC16_ROWS = 14;

    // Circulation start state for the 8-state code, row (N mod 7)-1, column end state.
    localparam logic [2:0] CIRC8 [CIRC8_ROWS][8] = '{
        '{3'd0, 3'd6, 3'd4, 3'd2, 3'd7, 3'd1, 3'd3, 3'd5},
        '{3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6, 3'd2, 3'd1},
        '{3'd0, 3'd5, 3'd3, 3'd6, 3'd2, 3'd7, 3'd1, 3'd4},
        '{3'd0, 3'd4, 3'd1, 3'd5, 3'd6, 3'd2, 3'd7, 3'd3},
        '{3'd0, 3'd2, 3'd5, 3'd7, 3'd1, 3'd3, 3'd4, 3'd6},
        '{3'd0, 3'd7, 3'd6, 3'd1, 3'd3, 3'd4, 3'd5, 3'd2}
    };

    // Circulation start state for the 16-state code, row (N mod 15)-1, column end state.
    localparam logic [3:0] CIRC16 [CIRC16_ROWS][16] = '{
        '{4'd0, 4'd14, 4'd3, 4'd13, 4'd7, 4'd9, 4'd4, 4'd10,
          4'd15, 4'd1, 4'd12, 4'd2, 4'd8, 4'd6, 4'd11, 4'd5},
        '{4'd0, 4'd11, 4'd13, 4'd6, 4'd10, 4'd1, 4'd7, 4'd12,
          4'd5, 4'd14, 4'd8, 4'd3, 4'd15, 4'd4, 4'd2, 4'd9},
        '{4'd0, 4'd8, 4'd9, 4'd1, 4'd2, 4'd10, 4'd11, 4'd3,
          4'd4, 4'd12, 4'd13, 4'd5, 4'd6, 4'd14, 4'd15, 4'd7},
        '{4'd0, 4'd3, 4'd4, 4'd7, 4'd8, 4'd11, 4'd12, 4'd15,
          4'd1, 4'd2, 4'd5, 4'd6, 4'd9, 4'd10, 4'd13, 4'd14},
        '{4'd0, 4'd12, 4'd5, 4'd9, 4'd11, 4'd7, 4'd14, 4'd2,
          4'd6, 4'd10, 4'd3, 4'd15, 4'd13, 4'd1, 4'd8, 4'd4},
        '{4'd0, 4'd4, 4'd12, 4'd8, 4'd9, 4'd13, 4'd5, 4'd1,
          4'd2, 4'd6, 4'd14, 4'd10, 4'd11, 4'd15, 4'd7, 4'd3},
        '{4'd0, 4'd6, 4'd10, 4'd12, 4'd5, 4'd3, 4'd15, 4'd9,
          4'd11, 4'd13, 4'd1, 4'd7, 4'd14, 4'd8, 4'd4, 4'd2},
        '{4'd0, 4'd7, 4'd8, 4'd15, 4'd1, 4'd6, 4'd9, 4'd14,
          4'd3, 4'd4, 4'd11, 4'd12, 4'd2, 4'd5, 4'd10, 4'd13},
        '{4'd0, 4'd5, 4'd14, 4'd11, 4'd13, 4'd8, 4'd3, 4'd6,
          4'd10, 4'd15, 4'd4, 4'd1, 4'd7, 4'd2, 4'd9, 4'd12},
        '{4'd0, 4'd13, 4'd7, 4'd10, 4'd15, 4'd2, 4'd8, 4'd5,
          4'd14, 4'd3, 4'd9, 4'd4, 4'd1, 4'd12, 4'd6, 4'd11},
        '{4'd0, 4'd2, 4'd6, 4'd4, 4'd12, 4'd14, 4'd10, 4'd8,
          4'd9, 4'd11, 4'd15, 4'd13, 4'd5, 4'd7, 4'd3, 4'd1},
        '{4'd0, 4'd9, 4'd11, 4'd2, 4'd6, 4'd15, 4'd13, 4'd4,
          4'd12, 4'd5, 4'd7, 4'd14, 4'd10, 4'd3, 4'd1, 4'd8},
        '{4'd0, 4'd10, 4'd15, 4'd5, 4'd14, 4'd4, 4'd1, 4'd11,
          4'd13, 4'd7, 4'd2, 4'd8, 4'd3, 4'd9, 4'd12, 4'd6},
        '{4'd0, 4'd15, 4'd1, 4'd14, 4'd3, 4'd12, 4'd2, 4'd13,
          4'd7, 4'd8, 4'd6, 4'd9, 4'd4, 4'd11, 4'd5, 4'd10}
    };

    // Next trellis state; st must already be masked to the code's state count.
    function automatic logic [3:0] rsc_next_state(logic sel, logic [3:0] st, logic a, logic b);
        logic [3:0] nxt;
        if (sel)
        begin
            nxt = {st[1] ^ st[0] ^ a ^ b, st[3] ^ b, st[2], st[1] ^ b};
        end
        else
        begin
            nxt = {1'b0, st[2] ^ st[0] ^ a ^ b, st[2] ^ b, st[1] ^ b};
        end
        return nxt;
    endfunction

    // Parity pair {Y, W} for one couple leaving state st.
    function automatic logic [1:0] rsc_parity(logic sel, logic [3:0] st, logic a, logic b);
        logic       fb;
        logic [1:0] yw;
        if (sel)
        begin
            fb = st[1] ^ st[0] ^ a ^ b;
            yw = {fb ^ st[3] ^ st[2] ^ st[0], fb ^ st[2] ^ st[1] ^ st[0]};
        end
        else
        begin
            fb = st[2] ^ st[0] ^ a ^ b;
            yw = {fb ^ st[1] ^ st[0], fb ^ st[0]};
        end
        return yw;
    endfunction

    // Circulation state lookup; rows outside the table give zero.
    function automatic logic [3:0] circ_start(logic sel, logic [3:0] row, logic [3:0] col);
        logic [3:0] v;
        v = 4'd0;
        if (sel)
        begin
            if (row < 4'(CIRC16_ROWS))
            begin
                v = CIRC16[row][col];
            end
        end
        else if (row < 4'(CIRC8_ROWS))
        begin
            v = {1'b0, CIRC8[row[2:0]][col[2:0]]};
        end
        return v;
    endfunction

endpackage

// ===== rtl/duobinary_circular_rsc_encoder_core.sv =====
// Write transfers produce no result; a new item can follow at once.
// A read transfer starts the couple store's registered read at its accepting edge; the trellis
// step is taken in the read state, and the result enters the output register as the block leaves
// that state. The input stalls in the read state, so a new read is taken only once the last result
// is registered, and a read waits there for as long as an earlier result is stalled in the output register.
// Reset clears the frame state, counters and output valid; the couple store is not cleared.
module duobinary_circular_rsc_encoder_core #(
    parameter int MAX_COUPLES = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dbcrsc_pkg::in_item_t in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dbcrsc_pkg::out_item_t out_data
);

    import dbcrsc_pkg::*;

    localparam int AW = (MAX_COUPLES > 1) ? $clog2(MAX_COUPLES) : 1;
    localparam int CW = $clog2(MAX_COUPLES + 2);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_COUPLES);

    // Registers.
    fsm_t           fsm_reg, fsm_next;
    logic           standard_select_reg;
    logic [3:0]     trellis_state_reg, trellis_state_next;
    logic [3:0]     start_state_reg, start_state_next;
    logic [CW-1:0]  couple_count_reg, couple_count_next;
    logic [CW-1:0]  read_index_reg, read_index_next;
    logic [2:0]     res7_reg, res7_next;
    logic [3:0]     res15_reg, res15_next;
    logic           frame_ready_reg, frame_ready_next;
    logic           length_error_reg, length_error_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_data_reg, out_data_next;

    // Combinational helpers.
    logic           accept_in;
    logic           out_free;
    logic           sel;
    logic [3:0]     smask;
    logic           fresh;
    logic [CW-1:0]  wr_count;
    logic [CW-1:0]  wr_count_new;
    logic [3:0]     wr_trellis;
    logic [3:0]     wr_trellis_new;
    logic [2:0]     wr_res7;
    logic [3:0]     wr_res15;
    logic [3:0]     circ_row;
    logic [3:0]     circ_pick;
    logic           mem_we;
    logic           mem_re;
    logic [1:0]     mem_rdata;
    logic [3:0]     rd_trellis;
    logic [1:0]     rd_parity;
    logic [CW-1:0]  rd_index_inc;

    // Couple store.
    dbcrsc_store #(
        .DEPTH (MAX_COUPLES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_count[AW-1:0]),
        .wr_data ({in_data.in_bit_a, in_data.in_bit_b}),
        .rd_en   (mem_re),
        .rd_addr (read_index_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    assign in_stall  = (fsm_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sel       = standard_select_reg;
    assign smask     = sel ? 4'hF : 4'h7;

    // Write path: a closed or flagged frame is discarded before the new couple.
    assign fresh    = frame_ready_reg || length_error_reg;
    assign wr_count = fresh ? '0 : couple_count_reg;
    assign wr_trellis = fresh ? 4'd0 : trellis_state_reg;
    assign wr_res7  = fresh ? 3'd0 : res7_reg;
    assign wr_res15 = fresh ? 4'd0 : res15_reg;

    // Read path: one trellis step on the couple fetched from the store.
    assign rd_trellis   = rsc_next_state(sel, trellis_state_reg & smask,
                                         mem_rdata[1], mem_rdata[0]);
    assign rd_parity    = rsc_parity(sel, trellis_state_reg & smask,
                                     mem_rdata[1], mem_rdata[0]);
    assign rd_index_inc = read_index_reg + CW'(1);

    // Controller: next state, store access and result formation.
    always_comb
    begin
        fsm_next           = fsm_reg;
        trellis_state_next = trellis_state_reg;
        start_state_next   = start_state_reg;
        couple_count_next  = couple_count_reg;
        read_index_next    = read_index_reg;
        res7_next          = res7_reg;
        res15_next         = res15_reg;
        frame_ready_next   = frame_ready_reg;
        length_error_next  = length_error_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_data_next      = out_data_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        wr_trellis_new     = wr_trellis;
        wr_count_new       = wr_count;
        circ_row           = 4'd0;
        circ_pick          = 4'd0;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (in_data.op == OP_WRITE)
                    begin
                        frame_ready_next  = 1'b0;
                        length_error_next = 1'b0;
                        res7_next         = wr_res7;
                        res15_next        = wr_res15;
                        if (wr_count < MAX_COUNT)
                        begin
                            mem_we         = 1'b1;
                            wr_trellis_new = rsc_next_state(sel, wr_trellis & smask,
                                                            in_data.in_bit_a,
                                                            in_data.in_bit_b);
                        end
                        if (wr_count <= MAX_COUNT)
                        begin
                            wr_count_new = wr_count + CW'(1);
                            res7_next    = (wr_res7 == 3'd6) ? 3'd0 : wr_res7 + 3'd1;
                            res15_next   = (wr_res15 == 4'd14) ? 4'd0 : wr_res15 + 4'd1;
                        end
                        couple_count_next  = wr_count_new;
                        trellis_state_next = wr_trellis_new;
                        // Close the frame: pick the circulation state or flag the length.
                        if (in_data.in_last)
                        begin
                            circ_row = (sel ? res15_next : {1'b0, res7_next}) - 4'd1;
                            if (wr_count_new > MAX_COUNT ||
                                (sel ? res15_next : {1'b0, res7_next}) == 4'd0)
                            begin
                                length_error_next = 1'b1;
                            end
                            else
                            begin
                                circ_pick          = circ_start(sel, circ_row,
                                                                wr_trellis_new & smask);
                                start_state_next   = circ_pick;
                                trellis_state_next = circ_pick;
                                read_index_next    = '0;
                                frame_ready_next   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        mem_re   = 1'b1;
                        fsm_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    fsm_next       = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    priority if (length_error_reg)
                    begin
                        out_data_next.status = STAT_BAD_LEN;
                    end
                    else if (!frame_ready_reg || read_index_reg >= couple_count_reg)
                    begin
                        out_data_next.status = STAT_NO_FRAME;
                    end
                    else
                    begin
                        out_data_next.out_bit_a = mem_rdata[1];
                        out_data_next.out_bit_b = mem_rdata[0];
                        out_data_next.parity_y  = rd_parity[1];
                        out_data_next.parity_w  = rd_parity[0];
                        out_data_next.status    = STAT_OK;
                        read_index_next         = rd_index_inc;
                        trellis_state_next      = rd_trellis;
                        // Last couple: check circulation and release the frame.
                        if (rd_index_inc == couple_count_reg)
                        begin
                            out_data_next.out_last = 1'b1;
                            if (rd_trellis != start_state_reg)
                            begin
                                out_data_next.status = STAT_MISMATCH;
                            end
                            frame_ready_next   = 1'b0;
                            couple_count_next  = '0;
                            read_index_next    = '0;
                            trellis_state_next = 4'd0;
                            res7_next          = 3'd0;
                            res15_next         = 4'd0;
                        end
                    end
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg             <= ST_IDLE;
            standard_select_reg <= 1'b0;
            trellis_state_reg   <= 4'd0;
            start_state_reg     <= 4'd0;
            couple_count_reg    <= '0;
            read_index_reg      <= '0;
            res7_reg            <= 3'd0;
            res15_reg           <= 4'd0;
            frame_ready_reg     <= 1'b0;
            length_error_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            fsm_reg           <= fsm_next;
            if (cfg_write)
            begin
                standard_select_reg <= cfg_data;
            end
            trellis_state_reg <= trellis_state_next;
            start_state_reg   <= start_state_next;
            couple_count_reg  <= couple_count_next;
            read_index_reg    <= read_index_next;
            res7_reg          <= res7_next;
            res15_reg         <= res15_next;
            frame_ready_reg   <= frame_ready_next;
            length_error_reg  <= length_error_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A frame is never both ready and flagged invalid.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(frame_ready_reg && length_error_reg))
        else $error("frame ready and length error set together");

    // While a frame is ready, the read pointer stays inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (read_index_reg < couple_count_reg))
        else $error("read index outside ready frame");

    // The couple count saturates one above the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        couple_count_reg <= MAX_COUNT + CW'(1))
        else $error("couple count overflow");

    // A result marked last is always a real couple transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.out_last) |->
            (out_data_reg.status == STAT_OK || out_data_reg.status == STAT_MISMATCH))
        else $error("last marker on an error result");

    // A read result is valid in the cycle after the read state finds room at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_READ && out_free) |=> (out_valid_reg && fsm_reg == ST_IDLE))
        else $error("read result not delivered");

endmodule

// ===== rtl/dbcrsc_store.sv =====
// Couple store: single-port-write, registered-read memory of two-bit couples.
module dbcrsc_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the duo-binary circular RSC encoder core.
module testbench;
    import dbcrsc_pkg::*;

    localparam int MAX_COUPLES  = 2048;
    localparam int PHASE_ITEMS  = 160;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    // Circulation start states, row (N mod (S-1))-1, column pre-encoding end state.
    localparam logic [2:0] CIRC_RCS1 [6][8] = '{
        '{3'd0, 3'd6, 3'd4, 3'd2, 3'd7, 3'd1, 3'd3, 3'd5},
        '{3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6, 3'd2, 3'd1},
        '{3'd0, 3'd5, 3'd3, 3'd6, 3'd2, 3'd7, 3'd1, 3'd4},
        '{3'd0, 3'd4, 3'd1, 3'd5, 3'd6, 3'd2, 3'd7, 3'd3},
        '{3'd0, 3'd2, 3'd5, 3'd7, 3'd1, 3'd3, 3'd4, 3'd6},
        '{3'd0, 3'd7, 3'd6, 3'd1, 3'd3, 3'd4, 3'd5, 3'd2}
    };
    localparam logic [3:0] CIRC_RCS2 [14][16] = '{
        '{4'd0, 4'd14, 4'd3, 4'd13, 4'd7, 4'd9, 4'd4, 4'd10,
          4'd15, 4'd1, 4'd12, 4'd2, 4'd8, 4'd6, 4'd11, 4'd5},
        '{4'd0, 4'd11, 4'd13, 4'd6, 4'd10, 4'd1, 4'd7, 4'd12,
          4'd5, 4'd14, 4'd8, 4'd3, 4'd15, 4'd4, 4'd2, 4'd9},
        '{4'd0, 4'd8, 4'd9, 4'd1, 4'd2, 4'd10, 4'd11, 4'd3,
          4'd4, 4'd12, 4'd13, 4'd5, 4'd6, 4'd14, 4'd15, 4'd7},
        '{4'd0, 4'd3, 4'd4, 4'd7, 4'd8, 4'd11, 4'd12, 4'd15,
          4'd1, 4'd2, 4'd5, 4'd6, 4'd9, 4'd10, 4'd13, 4'd14},
        '{4'd0, 4'd12, 4'd5, 4'd9, 4'd11, 4'd7, 4'd14, 4'd2,
          4'd6, 4'd10, 4'd3, 4'd15, 4'd13, 4'd1, 4'd8, 4'd4},
        '{4'd0, 4'd4, 4'd12, 4'd8, 4'd9, 4'd13, 4'd5, 4'd1,
          4'd2, 4'd6, 4'd14, 4'd10, 4'd11, 4'd15, 4'd7, 4'd3},
        '{4'd0, 4'd6, 4'd10, 4'd12, 4'd5, 4'd3, 4'd15, 4'd9,
          4'd11, 4'd13, 4'd1, 4'd7, 4'd14, 4'd8, 4'd4, 4'd2},
        '{4'd0, 4'd7, 4'd8, 4'd15, 4'd1, 4'd6, 4'd9, 4'd14,
          4'd3, 4'd4, 4'd11, 4'd12, 4'd2, 4'd5, 4'd10, 4'd13},
        '{4'd0, 4'd5, 4'd14, 4'd11, 4'd13, 4'd8, 4'd3, 4'd6,
          4'd10, 4'd15, 4'd4, 4'd1, 4'd7, 4'd2, 4'd9, 4'd12},
        '{4'd0, 4'd13, 4'd7, 4'd10, 4'd15, 4'd2, 4'd8, 4'd5,
          4'd14, 4'd3, 4'd9, 4'd4, 4'd1, 4'd12, 4'd6, 4'd11},
        '{4'd0, 4'd2, 4'd6, 4'd4, 4'd12, 4'd14, 4'd10, 4'd8,
          4'd9, 4'd11, 4'd15, 4'd13, 4'd5, 4'd7, 4'd3, 4'd1},
        '{4'd0, 4'd9, 4'd11, 4'd2, 4'd6, 4'd15, 4'd13, 4'd4,
          4'd12, 4'd5, 4'd7, 4'd14, 4'd10, 4'd3, 4'd1, 4'd8},
        '{4'd0, 4'd10, 4'd15, 4'd5, 4'd14, 4'd4, 4'd1, 4'd11,
          4'd13, 4'd7, 4'd2, 4'd8, 4'd3, 4'd9, 4'd12, 4'd6},
        '{4'd0, 4'd15, 4'd1, 4'd14, 4'd3, 4'd12, 4'd2, 4'd13,
          4'd7, 4'd8, 4'd6, 4'd9, 4'd4, 4'd11, 4'd5, 4'd10}
    };

    // Kind of a row in the directed stimulus table.
    typedef enum logic
    {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    // One directed row; a configuration row carries the standard in in_bit_a.
    typedef struct
    {
        row_kind_t kind;
        in_item_t  item;
        bit        fixed;
        status_t   status;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write = 1'b0;
    logic      cfg_data = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // Predictor state.
    bit         std_sel = 1'b0;
    logic [1:0] couple_mem [MAX_COUPLES];
    logic [3:0] enc_state = 4'd0;
    int         frame_len = 0;
    int         rd_ptr = 0;
    logic [3:0] start_exp = 4'd0;
    bit         frame_ok = 1'b0;
    bit         len_bad = 1'b0;

    out_item_t  coded_exp_q [$];
    dir_row_t   dir_tab [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int status_seen [4] = '{default: 0};
    int cycle_cnt = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    out_item_t mon_want;

    duobinary_circular_rsc_encoder_core #(
        .MAX_COUPLES (MAX_COUPLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Clock with a period of 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One trellis step of the selected code, with the parities of the couple.
    function automatic logic [3:0] trellis_step(input bit sel, input logic [3:0] st,
                                                input bit a, input bit b,
                                                output bit py, output bit pw);
        int         n;
        int         i;
        bit [0:3]   pa;
        bit [0:3]   pb;
        bit [0:3]   pf;
        bit [0:4]   pyv;
        bit [0:4]   pwv;
        bit         fb;
        bit         f;
        logic [3:0] nxt;
        n   = sel ? 4 : 3;
        pa  = 4'b1000;
        pb  = sel ? 4'b1101 : 4'b1110;
        pf  = sel ? 4'b0011 : 4'b1010;
        pyv = sel ? 5'b11101 : 5'b10110;
        pwv = sel ? 5'b10111 : 5'b10010;
        // Feedback bit enters the top of the register.
        fb = 1'b0;
        for (i = 0; i < n; i++)
        begin
            fb ^= st[i] & pf[n - 1 - i];
        end
        fb ^= (a & pa[0]) ^ (b & pb[0]);
        nxt = {3'b000, fb};
        py  = fb & pyv[0];
        pw  = fb & pwv[0];
        for (i = 1; i < n; i++)
        begin
            f   = st[n - i] ^ (a & pa[i]) ^ (b & pb[i]);
            nxt = {nxt[2:0], f};
        end
        for (i = 1; i <= n; i++)
        begin
            py ^= st[n - i] & pyv[i];
            pw ^= st[n - i] & pwv[i];
        end
        return nxt;
    endfunction

    // Expected coded couple for one accepted input transfer; returns 1 when a read yields one.
    function automatic bit predict_coded_couple(input in_item_t it, output out_item_t res);
        logic [3:0] smask;
        int         m;
        bit         py;
        bit         pw;
        logic [1:0] c;
        smask = std_sel ? 4'd15 : 4'd7;
        res = '0;
        res.status = STAT_OK;
        if (it.op == OP_WRITE)
        begin
            // A write after a closed or invalid frame opens a new one.
            if (frame_ok || len_bad)
            begin
                frame_ok  = 1'b0;
                len_bad   = 1'b0;
                frame_len = 0;
                enc_state = 4'd0;
            end
            if (frame_len < MAX_COUPLES)
            begin
                couple_mem[frame_len] = {it.in_bit_a, it.in_bit_b};
                enc_state = trellis_step(std_sel, enc_state & smask, it.in_bit_a, it.in_bit_b,
                                         py, pw);
            end
            if (frame_len <= MAX_COUPLES)
            begin
                frame_len++;
            end
            if (it.in_last)
            begin
                m = frame_len % int'(smask);
                if (frame_len > MAX_COUPLES || m == 0)
                begin
                    len_bad = 1'b1;
                end
                else
                begin
                    start_exp = std_sel ? CIRC_RCS2[m - 1][enc_state & smask]
                                        : {1'b0, CIRC_RCS1[m - 1][enc_state[2:0]]};
                    enc_state = start_exp;
                    rd_ptr    = 0;
                    frame_ok  = 1'b1;
                end
            end
            return 1'b0;
        end
        if (len_bad)
        begin
            res.status = STAT_BAD_LEN;
        end
        else if (!frame_ok || rd_ptr >= frame_len)
        begin
            res.status = STAT_NO_FRAME;
        end
        else
        begin
            // Re-encode the stored couple from the circulation state.
            c = couple_mem[rd_ptr];
            enc_state = trellis_step(std_sel, enc_state & smask, c[1], c[0], py, pw);
            res.out_bit_a = c[1];
            res.out_bit_b = c[0];
            res.parity_y  = py;
            res.parity_w  = pw;
            rd_ptr++;
            if (rd_ptr == frame_len)
            begin
                res.out_last = 1'b1;
                if (enc_state != start_exp)
                begin
                    res.status = STAT_MISMATCH;
                end
                frame_ok  = 1'b0;
                frame_len = 0;
                rd_ptr    = 0;
                enc_state = 4'd0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void add_row(row_kind_t kind, op_t op, bit a, bit b, bit last,
                                    bit fixed, status_t st);
        dir_row_t row;
        row.kind           = kind;
        row.item.op        = op;
        row.item.in_bit_a  = a;
        row.item.in_bit_b  = b;
        row.item.in_last   = last;
        row.fixed          = fixed;
        row.status         = st;
        dir_tab.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Drive one input transfer after a random gap and record its expected result.
    task automatic send_item(in_item_t it, bit fixed, status_t fixed_st);
        int        gap;
        bit        has_res;
        out_item_t res;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        has_res = predict_coded_couple(it, res);
        if (has_res)
        begin
            if (fixed)
            begin
                res = '0;
                res.status = fixed_st;
            end
            coded_exp_q.push_back(res);
        end
        items_sent++;
    endtask

    // Stop offering, wait for all expected results, then let the pipeline settle.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (coded_exp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_standard(bit value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        std_sel = value;
        cfg_writes++;
    endtask

    // Write n couples with the last marked, then issue nreads reads; reads may sneak in.
    task automatic send_frame(int n, int nreads, int noise_pct);
        int       k;
        in_item_t it;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                it = in_item_t'(4'($urandom_range(7)));
                it.op = OP_READ;
                send_item(it, 1'b0, STAT_OK);
            end
            it.op       = OP_WRITE;
            it.in_bit_a = 1'($urandom_range(1));
            it.in_bit_b = 1'($urandom_range(1));
            it.in_last  = (k == n - 1);
            send_item(it, 1'b0, STAT_OK);
        end
        for (k = 0; k < nreads; k++)
        begin
            it = in_item_t'(4'($urandom_range(7)));
            it.op = OP_READ;
            send_item(it, 1'b0, STAT_OK);
        end
    endtask

    // Mostly clean frames; some with invalid length, partial read-out or extra reads.
    task automatic random_frame();
        int n;
        int nrd;
        int pick;
        int span;
        span = std_sel ? 15 : 7;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0)
        begin
            n = $urandom_range(200, 60);
        end
        else
        begin
            n = $urandom_range(30, 1);
        end
        nrd = n;
        if (pick < 8)
        begin
            n   = span * $urandom_range(3, 1);
            nrd = $urandom_range(3, 1);
        end
        else if (pick < 16)
        begin
            nrd = $urandom_range(n - 1, 0);
        end
        else if (pick < 23)
        begin
            nrd = n + $urandom_range(3, 1);
        end
        send_frame(n, nrd, 4);
    endtask

    // Receiver: random stall, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (coded_exp_q.size() == 0)
            begin
                $error("result transfer with none expected: %b", out_data);
                errors++;
            end
            else
            begin
                mon_want = coded_exp_q.pop_front();
                check_field("out_bit_a", mon_want.out_bit_a, out_data.out_bit_a);
                check_field("out_bit_b", mon_want.out_bit_b, out_data.out_bit_b);
                check_field("parity_y", mon_want.parity_y, out_data.parity_y);
                check_field("parity_w", mon_want.parity_w, out_data.parity_w);
                check_field("out_last", mon_want.out_last, out_data.out_last);
                check_field("status", mon_want.status, out_data.status);
                status_seen[out_data.status]++;
            end
            results_seen++;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int rep;
        int mode;
        int start_cnt;

        // Directed table: reads with a typed status are checked against that value.
        //      kind      op        a     b     last  fixed status
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b1, STAT_NO_FRAME);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b1, 1'b1, 1'b1, 1'b1, STAT_NO_FRAME);
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b0, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b1, 1'b0, 1'b1, STAT_NO_FRAME);
        // Seven couples: no circulation state exists for the 8-state code.
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b0, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b1, STAT_BAD_LEN);
        add_row(ROW_ITEM, OP_READ,  1'b1, 1'b1, 1'b1, 1'b1, STAT_BAD_LEN);
        // A write after an invalid frame, then one that discards a ready frame.
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b1, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        // Standard changed between the writes and the reads of a frame.
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b0, 1'b1, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_CFG,  OP_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        // Standard changed in the middle of the writes.
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_CFG,  OP_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_WRITE, 1'b1, 1'b1, 1'b1, 1'b0, STAT_OK);
        add_row(ROW_CFG,  OP_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);
        add_row(ROW_ITEM, OP_READ,  1'b0, 1'b0, 1'b0, 1'b0, STAT_OK);

        // Reset.
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with no idling on either side.
        foreach (dir_tab[r])
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                wait_drain();
                write_standard(dir_tab[r].item.in_bit_a);
            end
            else
            begin
                send_item(dir_tab[r].item, dir_tab[r].fixed, dir_tab[r].status);
            end
        end

        // Random phases over both standards and each idling mix.
        for (rep = 0; rep < 2; rep++)
        begin
            for (mode = 0; mode < 4; mode++)
            begin
                wait_drain();
                write_standard(1'(rep ^ (mode & 1)));
                idle_pct  = (mode == 1) ? 65 : (mode == 3) ? 29 : 0;
                stall_pct = (mode == 2) ? 65 : (mode == 3) ? 29 : 0;
                if (rep == 0 && mode == 0)
                begin
                    // Receiver holds off while reads keep coming, then the sender pauses.
                    send_frame(40, 0, 0);
                    hold_seq++;
                    send_frame(0, 40, 0);
                    wait_drain();
                end
                start_cnt = items_sent;
                while (items_sent - start_cnt < PHASE_ITEMS)
                begin
                    random_frame();
                end
            end
        end

        // Let the last results come out with both sides active.
        idle_pct  = 0;
        stall_pct = 0;
        wait_drain();

        $display("Run covered %0d input transfers, %0d result transfers, %0d standard writes.",
                 items_sent, results_seen, cfg_writes);
        $display("Result status mix: ok %0d, no frame %0d, bad length %0d, end mismatch %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
